@@ rtl/aic_pkg.sv @@
// ----------------------------------------------------------------------------
// aic_pkg
// Shared widths, limits and sideband type for the inversion counter.
// ----------------------------------------------------------------------------
package aic_pkg;

    localparam int VALUE_W   = 8;
    localparam int TOTAL_W   = 11;
    // headroom for total plus one item's count (count stays below 1024)
    localparam int SUM_W     = 12;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

    // popcount tree: first level groups of GRP mask bits, second level
    // groups of GRP first-level counts
    localparam int GRP        = 8;
    localparam int GRP_CNT_W  = 4;
    localparam int SUP_CNT_W  = 7;

    typedef struct packed {
        logic last;
        logic too_long;
    } aic_tag_t;

endpackage

@@ rtl/aic_cells.sv @@
// ----------------------------------------------------------------------------
// aic_cells
// Value store with one comparator per cell; registers the greater-than mask.
// ----------------------------------------------------------------------------
module aic_cells
    import aic_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MAX_LEN-1:0] mask,
    output aic_tag_t           tag
);

    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [VALUE_W-1:0] held_reg [MAX_LEN];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               valid_reg;
    logic [MAX_LEN-1:0] mask_reg;
    logic [MAX_LEN-1:0] mask_next;
    aic_tag_t           tag_reg;
    aic_tag_t           tag_next;
    logic               full;
    logic               accept;
    logic [IDX_W-1:0]   wr_idx;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (fill_reg == FILL_W'(MAX_LEN));
    assign wr_idx    = fill_reg[IDX_W-1:0];
    assign out_valid = valid_reg;
    assign mask      = mask_reg;
    assign tag       = tag_reg;

    // only cells below the fill level take part; a full store compares nothing
    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            mask_next[i] = !full && (FILL_W'(i) < fill_reg) && (held_reg[i] > value);
        end
        tag_next.last     = last;
        tag_next.too_long = ovf_reg || full;
    end

    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (accept)
        begin
            if (last)
            begin
                fill_next = '0;
                ovf_next  = 1'b0;
            end
            else if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !full)
        begin
            held_reg[wr_idx] <= value;
        end
        if (accept)
        begin
            mask_reg <= mask_next;
            tag_reg  <= tag_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

endmodule

@@ rtl/aic_popcount.sv @@
// ----------------------------------------------------------------------------
// aic_popcount
// Two registered levels of population count over the greater-than mask.
// ----------------------------------------------------------------------------
module aic_popcount
    import aic_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int NG2     = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [MAX_LEN-1:0]               mask,
    input  aic_tag_t                         in_tag,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [NG2-1:0][SUP_CNT_W-1:0]    counts,
    output aic_tag_t                         out_tag
);

    localparam int NG1 = (MAX_LEN + GRP - 1) / GRP;

    logic [NG1*GRP-1:0]                 mask_pad;
    logic [NG1-1:0][GRP_CNT_W-1:0]      cnt1_next;
    logic [NG1-1:0][GRP_CNT_W-1:0]      cnt1_reg;
    aic_tag_t                           tag1_reg;
    logic                               valid1_reg;
    logic                               ready1;
    logic [NG2-1:0][SUP_CNT_W-1:0]      cnt2_next;
    logic [NG2-1:0][SUP_CNT_W-1:0]      cnt2_reg;
    aic_tag_t                           tag2_reg;
    logic                               valid2_reg;

    assign ready1    = !valid2_reg || out_ready;
    assign in_ready  = !valid1_reg || ready1;
    assign out_valid = valid2_reg;
    assign counts    = cnt2_reg;
    assign out_tag   = tag2_reg;

    always_comb
    begin
        mask_pad = '0;
        mask_pad[MAX_LEN-1:0] = mask;
        for (int g = 0; g < NG1; g++)
        begin
            cnt1_next[g] = '0;
            for (int b = 0; b < GRP; b++)
            begin
                cnt1_next[g] = cnt1_next[g] + GRP_CNT_W'(mask_pad[g*GRP+b]);
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < NG2; s++)
        begin
            cnt2_next[s] = '0;
            for (int g = 0; g < GRP; g++)
            begin
                if (s*GRP + g < NG1)
                begin
                    cnt2_next[s] = cnt2_next[s] + SUP_CNT_W'(cnt1_reg[s*GRP+g]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cnt1_reg <= cnt1_next;
            tag1_reg <= in_tag;
        end
        if (valid1_reg && ready1)
        begin
            cnt2_reg <= cnt2_next;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                valid1_reg <= in_valid;
            end
            if (ready1)
            begin
                valid2_reg <= valid1_reg;
            end
        end
    end

endmodule

@@ rtl/aic_accum.sv @@
// ----------------------------------------------------------------------------
// aic_accum
// Running total with saturation and the result register.
// ----------------------------------------------------------------------------
module aic_accum
    import aic_pkg::*;
#(
    parameter int NG2 = 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [NG2-1:0][SUP_CNT_W-1:0] counts,
    input  aic_tag_t                      in_tag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [TOTAL_W-1:0]            swap_count,
    output logic                          too_long
);

    logic [TOTAL_W-1:0] total_reg;
    logic [SUM_W-1:0]   add;
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] sat;
    logic               accept;
    logic               out_valid_reg;
    logic [TOTAL_W-1:0] count_reg;
    logic               too_long_reg;

    // beats that end no sequence never need the result slot
    assign in_ready   = !in_tag.last || !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign swap_count = count_reg;
    assign too_long   = too_long_reg;

    always_comb
    begin
        add = '0;
        for (int s = 0; s < NG2; s++)
        begin
            add = add + SUM_W'(counts[s]);
        end
        sum = SUM_W'(total_reg) + add;
        sat = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_tag.last)
        begin
            count_reg    <= sat;
            too_long_reg <= in_tag.too_long;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                total_reg <= in_tag.last ? '0 : sat;
            end
            if (accept && in_tag.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/adjacent_swap_inversion_counter_core.sv @@
// ----------------------------------------------------------------------------
// adjacent_swap_inversion_counter_core
// Counts the inversions of a value sequence, i.e. the least adjacent swaps.
//
// Slave channel: one 8-bit value per beat, tlast marks the final value of a
// sequence. Each value is compared in parallel against every value already
// stored for the sequence; the number of stored values strictly greater is
// added to a running total. Up to MAX_LEN values are stored; later ones are
// dropped and flag the result as too long (count partial).
// Master channel: one beat per sequence, on its tlast value, carrying the
// inversion count and the too-long flag. The store then clears itself.
// Throughput: one beat per cycle while the slave side is not stalled, set by
// the per-cell comparators and the registered popcount tree. After the edge
// that takes the last beat, the result passes the mask register (written at
// that edge), then two popcount levels and the result register.
// Reset clears the fill level, total and pipeline; stored values need no
// clearing. A stalled master side holds its result while value beats keep
// flowing; the slave side stalls only when a second result reaches the
// full output register.
// ----------------------------------------------------------------------------
module adjacent_swap_inversion_counter_core
    import aic_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] car_value
    input  logic        s_tlast,   // last_in_case
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [10:0] swap_count, [15:11] zero
    output logic        m_tuser    // too_long
);

    localparam int NG1 = (MAX_LEN + GRP - 1) / GRP;
    localparam int NG2 = (NG1 + GRP - 1) / GRP;

    logic                          c_valid;
    logic                          c_ready;
    logic [MAX_LEN-1:0]            c_mask;
    aic_tag_t                      c_tag;
    logic                          p_valid;
    logic                          p_ready;
    logic [NG2-1:0][SUP_CNT_W-1:0] p_counts;
    aic_tag_t                      p_tag;
    logic [TOTAL_W-1:0]            swap_count;

    aic_cells #(
        .MAX_LEN (MAX_LEN)
    ) u_cells (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .value     (s_tdata[VALUE_W-1:0]),
        .last      (s_tlast),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .mask      (c_mask),
        .tag       (c_tag)
    );

    aic_popcount #(
        .MAX_LEN (MAX_LEN),
        .NG2     (NG2)
    ) u_popcount (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_ready  (c_ready),
        .mask      (c_mask),
        .in_tag    (c_tag),
        .out_valid (p_valid),
        .out_ready (p_ready),
        .counts    (p_counts),
        .out_tag   (p_tag)
    );

    aic_accum #(
        .NG2 (NG2)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (p_valid),
        .in_ready   (p_ready),
        .counts     (p_counts),
        .in_tag     (p_tag),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .swap_count (swap_count),
        .too_long   (m_tuser)
    );

    assign m_tdata = {(16 - TOTAL_W)'(0), swap_count};

endmodule
